// ===== src/ckl_pkg.sv =====
// Package with the keyword table, codes and lexer helper functions of the keyword counter.
package ckl_pkg;

   localparam int MAX_WORD_LEN = 99;
   localparam int NUM_KEYWORDS = 14;
   localparam int COUNT_WIDTH  = 16;

   localparam int LEN_W   = $clog2(MAX_WORD_LEN + 1);
   localparam int ID_W    = 4;
   localparam int FUNC_W  = 2;
   localparam int OUT_CNT_W = 16;

   localparam logic [FUNC_W-1:0] FUNC_TEXT = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_END  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ = 2'd2;

   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_LF     = 8'h0A;

   localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
      "auto", "break", "case", "char", "const", "continue", "default",
      "if", "int", "struct", "unsigned", "void", "volatile", "while"
   };
   localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
      4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2, 4'd3, 4'd6, 4'd8, 4'd4, 4'd8, 4'd5
   };

   localparam logic [NUM_KEYWORDS-1:0] ALL_KEYS = '1;
   localparam logic [COUNT_WIDTH-1:0]  COUNT_MAX = '1;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic            valid;
      logic            readback;
      logic            hit;
      logic [ID_W-1:0] id;
   } lex_result_type;

   typedef struct packed {
      logic            hit;
      logic [ID_W-1:0] id;
   } kw_match_type;

   function automatic logic kw_is_letter(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
   endfunction

   function automatic logic kw_is_word_byte(input logic [7:0] c);
      return kw_is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == 8'h5F;
   endfunction

   function automatic logic kw_is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic [NUM_KEYWORDS-1:0] kw_narrow(
      input logic [NUM_KEYWORDS-1:0] mask,
      input logic [LEN_W-1:0]        pos,
      input logic [7:0]              c
   );
      logic [NUM_KEYWORDS-1:0] res;
      logic [7:0]              kc;
      int                      sh;
      res = mask;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         sh = (int'(KW_LEN[i]) - 1 - int'(pos[2:0])) * 8;
         if (sh < 0) sh = 0;
         kc = KW_TEXT[i][sh +: 8];
         if (!(pos < LEN_W'(KW_LEN[i]) && kc == c)) res[i] = 1'b0;
      end
      return res;
   endfunction

   function automatic kw_match_type kw_match(
      input logic [NUM_KEYWORDS-1:0] mask,
      input logic [LEN_W-1:0]        len
   );
      kw_match_type m;
      m = '0;
      for (int i = 0; i < NUM_KEYWORDS; i++) begin
         if (mask[i] && len == LEN_W'(KW_LEN[i])) begin
            m.hit = 1'b1;
            m.id  = ID_W'(i);
         end
      end
      return m;
   endfunction

endpackage

// ===== src/ckl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ckl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 14
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== src/ckl_lexer.sv =====
// Byte-serial lexer that tracks the scan state and reports finished words and count reads.
module ckl_lexer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [ckl_pkg::FUNC_W-1:0]    func,
   input  logic [7:0]                    ch,
   input  logic [ckl_pkg::ID_W-1:0]      key_index,
   output ckl_pkg::lex_result_type       result
);
   import ckl_pkg::*;

   localparam logic [2:0] MODE_IDLE   = 3'd0;
   localparam logic [2:0] MODE_WORD   = 3'd1;
   localparam logic [2:0] MODE_LINE   = 3'd2;
   localparam logic [2:0] MODE_DQUOTE = 3'd3;
   localparam logic [2:0] MODE_SQUOTE = 3'd4;
   localparam logic [2:0] MODE_HASH   = 3'd5;

   logic [2:0]              mode_ff, mode_in;
   logic                    pend_ff, pend_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic [NUM_KEYWORDS-1:0] mask_ff, mask_in;
   lex_result_type          res;
   logic                    run_idle;
   logic [NUM_KEYWORDS-1:0] grown_mask;
   logic [LEN_W-1:0]        grown_len;
   kw_match_type            grown_match;
   kw_match_type            cur_match;

   assign grown_mask  = kw_narrow(mask_ff, len_ff, ch);
   assign grown_len   = len_ff + LEN_W'(1);
   assign grown_match = kw_match(grown_mask, grown_len);
   assign cur_match   = kw_match(mask_ff, len_ff);

   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      len_in   = len_ff;
      mask_in  = mask_ff;
      res      = '0;
      run_idle = 1'b0;
      unique case (func)
         FUNC_READ: begin
            res.valid    = 1'b1;
            res.readback = 1'b1;
            res.id       = key_index;
         end
         FUNC_END: begin
            pend_in = 1'b0;
            mode_in = MODE_IDLE;
            if (mode_ff == MODE_WORD) begin
               res.valid = 1'b1;
               res.hit   = cur_match.hit;
               res.id    = cur_match.id;
               len_in    = '0;
               mask_in   = ALL_KEYS;
            end
         end
         FUNC_TEXT: begin
            unique case (mode_ff)
               MODE_WORD: begin
                  if (kw_is_word_byte(ch)) begin
                     mask_in = grown_mask;
                     len_in  = grown_len;
                     if (grown_len >= LEN_W'(MAX_WORD_LEN)) begin
                        res.valid = 1'b1;
                        res.hit   = grown_match.hit;
                        res.id    = grown_match.id;
                        mode_in   = MODE_IDLE;
                        len_in    = '0;
                        mask_in   = ALL_KEYS;
                     end
                  end else begin
                     res.valid = 1'b1;
                     res.hit   = cur_match.hit;
                     res.id    = cur_match.id;
                     mode_in   = MODE_IDLE;
                     len_in    = '0;
                     mask_in   = ALL_KEYS;
                     run_idle  = 1'b1;
                  end
               end
               MODE_LINE: begin
                  if (ch == CH_LF) mode_in = MODE_IDLE;
               end
               MODE_DQUOTE: begin
                  if (ch == CH_DQUOTE) mode_in = MODE_IDLE;
               end
               MODE_SQUOTE: begin
                  if (ch == CH_SQUOTE) mode_in = MODE_IDLE;
               end
               MODE_HASH: begin
                  if (ch == CH_SPACE) mode_in = MODE_IDLE;
               end
               default: begin
                  mode_in = MODE_IDLE;
                  if (pend_ff) begin
                     pend_in = 1'b0;
                     if (ch == CH_SLASH) begin
                        mode_in = MODE_LINE;
                     end else begin
                        run_idle = 1'b1;
                     end
                  end else begin
                     run_idle = 1'b1;
                  end
               end
            endcase
         end
         default: begin
         end
      endcase

      if (run_idle && !kw_is_blank(ch)) begin
         priority if (kw_is_letter(ch)) begin
            mode_in = MODE_WORD;
            mask_in = kw_narrow(ALL_KEYS, '0, ch);
            len_in  = LEN_W'(1);
         end else if (ch == CH_SLASH) begin
            pend_in = 1'b1;
         end else if (ch == CH_DQUOTE) begin
            mode_in = MODE_DQUOTE;
         end else if (ch == CH_SQUOTE) begin
            mode_in = MODE_SQUOTE;
         end else if (ch == CH_HASH) begin
            mode_in = MODE_HASH;
         end else begin
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pend_ff <= 1'b0;
         len_ff  <= '0;
         mask_ff <= ALL_KEYS;
      end else if (accept) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         len_ff  <= len_in;
         mask_ff <= mask_in;
      end
   end

   always_comb begin
      result       = res;
      result.valid = res.valid && accept;
   end

endmodule

// ===== src/ckl_counter.sv =====
// Count memory with read-modify-write stage, write forwarding and the result register.
module ckl_counter (
   input  logic                                clock,
   input  logic                                reset,
   input  ckl_pkg::lex_result_type             result,
   output logic                                busy,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_is_readback,
   output logic                                rsp_matched,
   output logic [ckl_pkg::ID_W-1:0]            rsp_keyword_id,
   output logic [ckl_pkg::OUT_CNT_W-1:0]       rsp_keyword_count
);
   import ckl_pkg::*;

   localparam int ADDR_W = $clog2(NUM_KEYWORDS);

   logic                    s1_valid_ff;
   logic                    s1_rb_ff;
   logic                    s1_hit_ff;
   logic                    s1_inrange_ff;
   logic [ID_W-1:0]         s1_id_ff;
   logic                    s1_adv;
   logic                    ld_inrange;

   logic [NUM_KEYWORDS-1:0] cnt_valid_ff;
   logic                    fwd_valid_ff;
   logic [ADDR_W-1:0]       fwd_addr_ff;
   count_type               fwd_data_ff;

   logic                    ram_we;
   logic                    ram_re;
   count_type               ram_rdata;
   count_type               old_cnt;
   count_type               new_cnt;
   count_type               out_cnt;

   logic                    rsp_valid_ff;
   logic                    rsp_rb_ff;
   logic                    rsp_hit_ff;
   logic [ID_W-1:0]         rsp_id_ff;
   count_type               rsp_cnt_ff;

   assign ld_inrange = int'(result.id) < NUM_KEYWORDS;
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign busy       = s1_valid_ff && !s1_adv;
   assign ram_re     = result.valid && ld_inrange;

   always_comb begin
      old_cnt = '0;
      if (s1_inrange_ff) begin
         priority if (fwd_valid_ff && fwd_addr_ff == s1_id_ff[ADDR_W-1:0]) begin
            old_cnt = fwd_data_ff;
         end else if (cnt_valid_ff[s1_id_ff[ADDR_W-1:0]]) begin
            old_cnt = ram_rdata;
         end else begin
            old_cnt = '0;
         end
      end
      new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + COUNT_WIDTH'(1);
      priority if (s1_rb_ff) begin
         out_cnt = old_cnt;
      end else if (s1_hit_ff) begin
         out_cnt = new_cnt;
      end else begin
         out_cnt = '0;
      end
   end

   assign ram_we = s1_adv && !s1_rb_ff && s1_hit_ff;

   ckl_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_KEYWORDS)
   ) u_count_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (s1_id_ff[ADDR_W-1:0]),
      .wdata (new_cnt),
      .re    (ram_re),
      .raddr (result.id[ADDR_W-1:0]),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_valid_ff <= '0;
         fwd_valid_ff <= 1'b0;
      end else begin
         if (result.valid) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ram_we) begin
            cnt_valid_ff[s1_id_ff[ADDR_W-1:0]] <= 1'b1;
            fwd_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         s1_rb_ff      <= result.readback;
         s1_hit_ff     <= result.hit;
         s1_id_ff      <= result.id;
         s1_inrange_ff <= ld_inrange;
      end
      if (ram_we) begin
         fwd_addr_ff <= s1_id_ff[ADDR_W-1:0];
         fwd_data_ff <= new_cnt;
      end
      if (s1_adv) begin
         rsp_rb_ff  <= s1_rb_ff;
         rsp_hit_ff <= s1_hit_ff && !s1_rb_ff;
         rsp_id_ff  <= (s1_rb_ff || s1_hit_ff) ? s1_id_ff : '0;
         rsp_cnt_ff <= out_cnt;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_readback   = rsp_rb_ff;
   assign rsp_matched       = rsp_hit_ff;
   assign rsp_keyword_id    = rsp_id_ff;
   assign rsp_keyword_count = OUT_CNT_W'(rsp_cnt_ff);

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stalled without a held transaction");

   a_write_on_advance: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> s1_valid_ff && s1_adv && !s1_rb_ff)
      else $error("count written outside a word transaction");

   a_match_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_readback && rsp_matched |-> rsp_keyword_count != '0)
      else $error("matched keyword reported a zero count");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_readback && !rsp_matched |->
         rsp_keyword_id == '0 && rsp_keyword_count == '0)
      else $error("unmatched word reported a nonzero id or count");

endmodule

// ===== src/c_keyword_lexer_counter.sv =====
// Top level of the C keyword lexer and frequency counter.
// The request channel carries one transaction per text byte (func = text),
// an end-of-input marker (func = end) or a count read (func = read with
// key_index). Each transaction is taken when req_valid is high and req_stall
// is low. A finished word or a count read produces one response transaction;
// other bytes produce none. A response shows whether it answers a read, whether
// the word was a keyword, the keyword index and its saturating count.
// On an accepted request the lexer updates its state in the accepting cycle
// and issues a read of the count memory; the count stage then increments,
// writes back and loads the response register once that register is free.
// One request is taken every cycle while responses drain; a back-to-back
// write and read of the same count is forwarded.
// Reset clears the scan state and marks every count as zero through per-entry
// valid flags, so no clearing pass is needed. When the receiver holds
// rsp_stall, one response waits in the output register and one more in the
// count stage; any further request, with or without a response, then sees
// req_stall until the output register drains.
module c_keyword_lexer_counter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [ckl_pkg::FUNC_W-1:0]       req_func,
   input  logic [7:0]                       req_ch,
   input  logic [ckl_pkg::ID_W-1:0]         req_key_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_is_readback,
   output logic                             rsp_matched,
   output logic [ckl_pkg::ID_W-1:0]         rsp_keyword_id,
   output logic [ckl_pkg::OUT_CNT_W-1:0]    rsp_keyword_count
);
   import ckl_pkg::*;

   logic           accept;
   logic           busy;
   lex_result_type lex_result;

   assign accept    = req_valid && !busy;
   assign req_stall = busy;

   ckl_lexer u_lexer (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .func      (req_func),
      .ch        (req_ch),
      .key_index (req_key_index),
      .result    (lex_result)
   );

   ckl_counter u_counter (
      .clock             (clock),
      .reset             (reset),
      .result            (lex_result),
      .busy              (busy),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_is_readback   (rsp_is_readback),
      .rsp_matched       (rsp_matched),
      .rsp_keyword_id    (rsp_keyword_id),
      .rsp_keyword_count (rsp_keyword_count)
   );

endmodule
